@@ rtl/mfph_pkg.sv @@
package mfph_pkg;

    localparam int HDR_BYTES = 8;
    localparam int CNT_W = $clog2(HDR_BYTES + 1);
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [15:0] MAX_SLICE_RST = 16'd1024;

    typedef struct packed {
        logic        hdr;
        logic [31:0] id;
        logic [31:0] part;
        logic [7:0]  data;
        logic        slice_last;
        logic        msg_last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

@@ rtl/mfph_in_if.sv @@
interface mfph_in_if;
    logic        valid;
    logic        ready;
    logic        first_byte;
    logic [31:0] msg_id;
    logic [7:0]  data_byte;
    logic        last_byte;

    modport source (
        output valid, first_byte, msg_id, data_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, first_byte, msg_id, data_byte, last_byte,
        output ready
    );
endinterface

@@ rtl/mfph_out_if.sv @@
interface mfph_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_header;
    logic       slice_last;
    logic       message_last;
    logic       run_last;

    modport source (
        output valid, out_byte, is_header, slice_last, message_last, run_last,
        input  ready
    );
    modport sink (
        input  valid, out_byte, is_header, slice_last, message_last, run_last,
        output ready
    );
endinterface

@@ rtl/mfph_front.sv @@
module mfph_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    mfph_in_if.sink             i_in,
    input  logic                i_q_ready,
    output mfph_pkg::t_push     o_push
);
    import mfph_pkg::*;

    logic [15:0] r_limit;
    logic [15:0] n_limit;
    logic [15:0] r_fill;
    logic [15:0] n_fill;
    logic [31:0] r_part;
    logic [31:0] n_part;
    logic [31:0] r_id;
    logic [31:0] n_id;

    logic        accept;
    logic [15:0] fill_eff;
    logic [31:0] part_eff;
    logic [31:0] id_eff;
    logic [16:0] fill_next;
    logic        open_slice;
    logic        end_slice;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;

    // payload limit per slice, header excluded, at least one byte
    always_comb begin
        n_limit = r_limit;
        if (i_cfg_we) begin
            if (i_cfg_wdata > 16'(HDR_BYTES)) begin
                n_limit = i_cfg_wdata - 16'(HDR_BYTES);
            end else begin
                n_limit = 16'd1;
            end
        end
    end

    always_comb begin
        fill_eff   = i_in.first_byte ? 16'd0 : r_fill;
        part_eff   = i_in.first_byte ? 32'd0 : r_part;
        id_eff     = i_in.first_byte ? i_in.msg_id : r_id;
        open_slice = (fill_eff == 16'd0);
        fill_next  = {1'b0, fill_eff} + 17'd1;
        end_slice  = (fill_next >= {1'b0, r_limit}) || i_in.last_byte;

        n_fill = r_fill;
        n_part = r_part;
        n_id   = r_id;
        if (accept) begin
            n_fill = end_slice ? 16'd0 : fill_next[15:0];
            n_part = open_slice ? part_eff + 32'd1 : part_eff;
            n_id   = id_eff;
        end

        o_push.valid           = accept;
        o_push.cmd.hdr         = open_slice;
        o_push.cmd.id          = id_eff;
        o_push.cmd.part        = part_eff;
        o_push.cmd.data        = i_in.data_byte;
        o_push.cmd.slice_last  = end_slice;
        o_push.cmd.msg_last    = i_in.last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= MAX_SLICE_RST - 16'(HDR_BYTES);
            r_fill  <= '0;
            r_part  <= '0;
            r_id    <= '0;
        end else begin
            r_limit <= n_limit;
            r_fill  <= n_fill;
            r_part  <= n_part;
            r_id    <= n_id;
        end
    end

endmodule

@@ rtl/mfph_queue.sv @@
module mfph_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mfph_pkg::t_push     i_push,
    output logic                o_ready,
    output mfph_pkg::t_head     o_head,
    input  logic                i_pop
);
    import mfph_pkg::*;

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic                push;
    logic                pop;

    assign o_ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign push    = i_push.valid && o_ready;
    assign pop     = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/mfph_back.sv @@
module mfph_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mfph_pkg::t_head     i_head,
    output logic                o_pop,
    mfph_out_if.source          o_out
);
    import mfph_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_valid;
    logic             n_valid;
    logic [7:0]       r_byte;
    logic [7:0]       n_byte;
    logic             r_hdr;
    logic             n_hdr;
    logic             r_slice_last;
    logic             n_slice_last;
    logic             r_msg_last;
    logic             n_msg_last;
    logic             r_run_last;
    logic             n_run_last;

    logic             load;
    logic [4:0]       bsel;
    logic [7:0]       hdr_byte;

    assign load = !r_valid || o_out.ready;
    assign bsel = {r_cnt[1:0], 3'b000};

    // header bytes: id then part number, little-endian
    assign hdr_byte = r_cnt[2] ? i_head.cmd.part[bsel +: 8] : i_head.cmd.id[bsel +: 8];

    always_comb begin
        n_cnt        = r_cnt;
        n_valid      = r_valid;
        n_byte       = r_byte;
        n_hdr        = r_hdr;
        n_slice_last = r_slice_last;
        n_msg_last   = r_msg_last;
        n_run_last   = r_run_last;
        o_pop        = 1'b0;
        if (load) begin
            if (i_head.valid) begin
                n_valid = 1'b1;
                if (i_head.cmd.hdr && (r_cnt != CNT_W'(HDR_BYTES))) begin
                    n_byte       = hdr_byte;
                    n_hdr        = 1'b1;
                    n_slice_last = 1'b0;
                    n_msg_last   = 1'b0;
                    n_run_last   = 1'b0;
                    n_cnt        = r_cnt + 1'b1;
                end else begin
                    n_byte       = i_head.cmd.data;
                    n_hdr        = 1'b0;
                    n_slice_last = i_head.cmd.slice_last;
                    n_msg_last   = i_head.cmd.msg_last;
                    n_run_last   = 1'b1;
                    n_cnt        = '0;
                    o_pop        = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_hdr        <= n_hdr;
        r_slice_last <= n_slice_last;
        r_msg_last   <= n_msg_last;
        r_run_last   <= n_run_last;
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = r_byte;
    assign o_out.is_header    = r_hdr;
    assign o_out.slice_last   = r_slice_last;
    assign o_out.message_last = r_msg_last;
    assign o_out.run_last     = r_run_last;

endmodule

@@ rtl/message_fragmenter_with_part_header.sv @@
// message fragmenter: payload bytes in, sliced byte stream with id/part headers out
// i_in: one payload byte per item with first_byte, msg_id and last_byte marks
// o_out: one byte per item; a slice opens with 8 header bytes (id, then part
//   number, little-endian), then up to max(max_slice_bytes - 8, 1) payload bytes
// i_cfg_we / i_cfg_wdata: write max_slice_bytes while the block is idle
// a taken item goes through the command queue into the output byte register
// throughput: one input byte per cycle inside a slice while the queue has room;
//   a byte that opens a slice follows its 8 header bytes through one byte register
// a 2-entry command queue between the front and back ends keeps the input
//   open while header bytes drain, until both entries are in use
// reset: max_slice_bytes returns to 1024, fill, part counter and id clear, the
//   queue and output register empty
// when o_out.ready is low the output byte holds, the queue fills and
//   i_in.ready drops once both entries are in use
module message_fragmenter_with_part_header (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    mfph_in_if.sink     i_in,
    mfph_out_if.source  o_out
);
    import mfph_pkg::*;

    t_push q_push;
    t_head q_head;
    logic  q_ready;
    logic  q_pop;

    mfph_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_ready   (q_ready),
        .o_push      (q_push)
    );

    mfph_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_ready (q_ready),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    mfph_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import mfph_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       slice_last;
        logic       message_last;
        logic       run_last;
    } t_frag_out;

    class slice_stream_checker;
        logic [15:0] max_slice;
        logic [15:0] fill;
        logic [31:0] part_no;
        logic [31:0] cur_id;
        t_frag_out   expected_bytes[$];
        int          fails;

        function new();
            max_slice = MAX_SLICE_RST;
            fill      = '0;
            part_no   = '0;
            cur_id    = '0;
            fails     = 0;
        endfunction

        function void set_limit(logic [15:0] value);
            max_slice = value;
        endfunction

        function int payload_limit();
            return (max_slice > HDR_BYTES) ? int'(max_slice) - HDR_BYTES : 1;
        endfunction

        function void push_byte(logic [7:0] b, logic hdr, logic sl, logic ml, logic rl);
            t_frag_out e;
            e.out_byte     = b;
            e.is_header    = hdr;
            e.slice_last   = sl;
            e.message_last = ml;
            e.run_last     = rl;
            expected_bytes.push_back(e);
        endfunction

        function void note_payload_byte(logic first, logic [31:0] id, logic [7:0] data,
                                        logic last);
            logic [16:0] fill_next;
            logic        closes;
            if (first) begin
                fill    = '0;
                part_no = '0;
                cur_id  = id;
            end
            if (fill == 0) begin
                for (int k = 0; k < 4; k++) begin
                    push_byte(cur_id[8*k +: 8], 1'b1, 1'b0, 1'b0, 1'b0);
                end
                for (int k = 0; k < 4; k++) begin
                    push_byte(part_no[8*k +: 8], 1'b1, 1'b0, 1'b0, 1'b0);
                end
                part_no = part_no + 32'd1;
            end
            fill_next = {1'b0, fill} + 17'd1;
            closes = (int'(fill_next) >= payload_limit()) || last;
            push_byte(data, 1'b0, closes, last, 1'b1);
            fill = closes ? 16'd0 : fill_next[15:0];
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                fails++;
            end
        endfunction

        function void check_out_byte(t_frag_out got);
            t_frag_out want;
            if (expected_bytes.size() == 0) begin
                $error("out_byte %0h arrived with nothing expected", got.out_byte);
                fails++;
                return;
            end
            want = expected_bytes.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("is_header", 8'(want.is_header), 8'(got.is_header));
            compare_field("slice_last", 8'(want.slice_last), 8'(got.slice_last));
            compare_field("message_last", 8'(want.message_last), 8'(got.message_last));
            compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    mfph_in_if  in_bus ();
    mfph_out_if out_bus ();

    slice_stream_checker slice_check;
    int sent_count;
    int recv_count;
    bit send_idle_on;
    bit recv_idle_on;

    message_fragmenter_with_part_header uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_byte(input logic first, input logic [31:0] id,
                             input logic [7:0] data, input logic last);
        int gap;
        if (sent_count % 40 == 0) begin
            send_idle_on = ($urandom_range(0, 2) != 0);
        end
        gap = send_idle_on ? $urandom_range(0, 9) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_bus.valid      <= 1'b1;
        in_bus.first_byte <= first;
        in_bus.msg_id     <= id;
        in_bus.data_byte  <= data;
        in_bus.last_byte  <= last;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        slice_check.note_payload_byte(first, id, data, last);
        sent_count++;
    endtask

    task automatic send_message(input logic [31:0] id, input int len,
                                input logic opens, input logic closes);
        for (int i = 0; i < len; i++) begin
            send_byte(opens && (i == 0), id, 8'($urandom_range(0, 255)),
                      closes && (i == len - 1));
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (slice_check.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_slice_limit(input logic [15:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        slice_check.set_limit(value);
    endtask

    task automatic random_phase(input int n_items);
        int done;
        int kind;
        int len;
        int max_len;
        done = 0;
        max_len = slice_check.payload_limit() * 3 + 1;
        if (max_len > 48) begin
            max_len = 48;
        end
        while (done < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                len = $urandom_range(1, max_len);
                send_message($urandom(), len, 1'b1, 1'b1);
            end else if (kind == 7) begin
                // stray continuation bytes
                len = $urandom_range(1, 3);
                send_message($urandom(), len, 1'b0, 1'($urandom_range(0, 1)));
            end else if (kind == 8) begin
                // message cut off by the next start
                len = $urandom_range(1, max_len);
                send_message($urandom(), len, 1'b1, 1'b0);
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) begin
                    send_byte(1'($urandom_range(0, 1)), $urandom(),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
            done += len;
        end
    endtask

    // result side
    initial begin
        int gap;
        t_frag_out got;
        out_bus.ready = 1'b0;
        recv_count = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (recv_count % 40 == 0) begin
                recv_idle_on = ($urandom_range(0, 2) != 0);
            end
            gap = recv_idle_on ? $urandom_range(0, 9) : 0;
            if (recv_count == 400 || recv_count == 1000) begin
                gap = HOLD_CYCLES;
            end
            repeat (gap) begin
                @(negedge i_clk);
                out_bus.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (out_bus.valid !== 1'b1);
            got.out_byte     = out_bus.out_byte;
            got.is_header    = out_bus.is_header;
            got.slice_last   = out_bus.slice_last;
            got.message_last = out_bus.message_last;
            got.run_last     = out_bus.run_last;
            slice_check.check_out_byte(got);
            recv_count++;
        end
    end

    // stall watchdog
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (in_bus.valid && in_bus.ready)
                || (out_bus.valid && out_bus.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] limits[6];
        slice_check = new();
        sent_count  = 0;
        send_idle_on = 1'b1;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        in_bus.valid      = 1'b0;
        in_bus.first_byte = 1'b0;
        in_bus.msg_id     = '0;
        in_bus.data_byte  = '0;
        in_bus.last_byte  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // continuation straight after reset, then one-byte message
        send_byte(1'b0, 32'h1234_5678, 8'h00, 1'b0);
        send_byte(1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        // continuation after the message ended
        send_byte(1'b0, 32'h0000_0000, 8'h5A, 1'b1);
        send_byte(1'b1, 32'h8000_0001, 8'h80, 1'b0);
        send_byte(1'b0, 32'h8000_0001, 8'h01, 1'b0);
        send_byte(1'b0, 32'h8000_0001, 8'h7F, 1'b1);
        // new start while a slice is open
        send_message(32'hDEAD_BEEF, 2, 1'b1, 1'b0);
        send_message(32'h0123_4567, 2, 1'b1, 1'b1);

        write_slice_limit(16'd9);
        send_message($urandom(), 4, 1'b1, 1'b1);
        // limit below header size saturates to one payload byte
        write_slice_limit(16'd4);
        send_message($urandom(), 3, 1'b1, 1'b1);
        write_slice_limit(16'd8);
        send_message($urandom(), 2, 1'b1, 1'b1);
        // open a long slice, then shrink the limit under its fill
        write_slice_limit(16'hFFFF);
        send_message($urandom(), 6, 1'b1, 1'b0);
        write_slice_limit(16'd10);
        send_message($urandom(), 4, 1'b0, 1'b1);

        limits[0] = 16'd9;
        limits[1] = 16'd10;
        limits[2] = 16'($urandom_range(11, 40));
        limits[3] = 16'd16;
        limits[4] = 16'd1024;
        limits[5] = 16'hFFFF;
        for (int p = 0; p < 6; p++) begin
            write_slice_limit(limits[p]);
            random_phase(50);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (slice_check.fails == 0 && slice_check.expected_bytes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mfph_pkg.sv
rtl/mfph_in_if.sv
rtl/mfph_out_if.sv
rtl/mfph_front.sv
rtl/mfph_queue.sv
rtl/mfph_back.sv
rtl/message_fragmenter_with_part_header.sv
sim/tb_top.sv
